/* hw/rtl/pt3_pkg.sv */
`default_nettype none

package pt3_pkg;

    localparam int COORD_BITS   = 32;
    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_BITS   = 16;
    localparam int SINE_ENTRIES = 1024;

    localparam int FIELD_W    = 32;
    localparam int OP_W       = 3;
    localparam int TRIG_FRAC  = 30;
    localparam int TRIG_W     = TRIG_FRAC + 2;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PASS_W     = COORD_BITS + 2;
    localparam int PROD_W     = DIFF_W + ((TRIG_W > COORD_BITS) ? TRIG_W : COORD_BITS);
    localparam int SUM_W      = PROD_W + 1;
    localparam int QUAD_W     = ANGLE_BITS - 2;
    localparam int IDX_LOG    = $clog2(SINE_ENTRIES);
    localparam int IDX_W      = IDX_LOG + 1;
    localparam int ENTRY_W    = TRIG_FRAC + 1;
    localparam longint unsigned TRIG_ONE    = 64'd1 << TRIG_FRAC;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [OP_W-1:0] {
        OP_TRANSLATE = 3'd0,
        OP_ROT_X     = 3'd1,
        OP_ROT_Y     = 3'd2,
        OP_ROT_Z     = 3'd3,
        OP_SCALE     = 3'd4
    } op_e;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic                      about_ref;
        logic signed [FIELD_W-1:0] point_x;
        logic signed [FIELD_W-1:0] point_y;
        logic signed [FIELD_W-1:0] point_z;
        logic signed [FIELD_W-1:0] ref_x;
        logic signed [FIELD_W-1:0] ref_y;
        logic signed [FIELD_W-1:0] ref_z;
        logic signed [15:0]        angle;
        logic signed [FIELD_W-1:0] arg_x;
        logic signed [FIELD_W-1:0] arg_y;
        logic signed [FIELD_W-1:0] arg_z;
    } pt3_req_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] out_x;
        logic signed [FIELD_W-1:0] out_y;
        logic signed [FIELD_W-1:0] out_z;
        logic                      overflow;
    } pt3_rsp_t;

    // after offset removal
    typedef struct packed {
        logic [OP_W-1:0]                 op;
        logic [2:0][DIFF_W-1:0]          d;
        logic [2:0][COORD_BITS-1:0]      r;
        logic [2:0][COORD_BITS-1:0]      a;
    } s1_t;

    // after multiply
    typedef struct packed {
        logic [OP_W-1:0]                 op;
        logic [2:0][COORD_BITS-1:0]      r;
        logic [2:0][PASS_W-1:0]          t;
        logic [3:0][PROD_W-1:0]          m;
    } s2_t;

    // exact result before saturation
    typedef struct packed {
        logic [2:0][SUM_W-1:0]           w;
    } s3_t;

    typedef logic [SINE_ENTRIES:0][ENTRY_W-1:0] sine_table_t;

    function automatic longint unsigned horner_term(longint unsigned t);
        return (t >= TRIG_ONE) ? 64'd0 : TRIG_ONE - t;
    endfunction

    function automatic sine_table_t build_sine_table();
        sine_table_t     tbl;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned s;
        for (int i = 0; i <= SINE_ENTRIES; i++) begin
            x    = (HALF_PI_Q30 * longint'(i) + SINE_ENTRIES / 2) / SINE_ENTRIES;
            x2   = (x * x + (TRIG_ONE >> 1)) >> TRIG_FRAC;
            term = TRIG_ONE;
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 272);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 210);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 156);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 110);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 72);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 42);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 20);
            term = horner_term(((x2 * term) >> TRIG_FRAC) / 6);
            s    = (x * term + (TRIG_ONE >> 1)) >> TRIG_FRAC;
            if (s > TRIG_ONE)
            begin
                s = TRIG_ONE;
            end
            tbl[i] = s[ENTRY_W-1:0];
        end
        return tbl;
    endfunction

    localparam sine_table_t SINE_TABLE = build_sine_table();

endpackage

`default_nettype wire

/* hw/rtl/pt3_stream_if.sv */
`default_nettype none

interface pt3_stream_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pt3_sine_rom.sv */
`default_nettype none

module pt3_sine_rom import pt3_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     en,
    input  wire logic [ANGLE_BITS-1:0]    angle,
    output logic signed [TRIG_W-1:0]      sine_reg,
    output logic signed [TRIG_W-1:0]      cosine_reg
);

    logic signed [TRIG_W-1:0] sine_next;
    logic signed [TRIG_W-1:0] cosine_next;

    // fold a quadrant and position onto the quarter-wave table
    function automatic logic signed [TRIG_W-1:0] quarter_lookup(
        input logic [1:0]        quad,
        input logic [QUAD_W-1:0] pos
    );
        logic [QUAD_W+IDX_W-1:0] scaled;
        logic [IDX_W-1:0]        idx;
        logic [IDX_W-1:0]        fidx;
        logic [TRIG_W-1:0]       mag;
        scaled = ((QUAD_W+IDX_W)'(pos) << IDX_LOG) + (QUAD_W+IDX_W)'(1 << (QUAD_W - 1));
        idx    = scaled[QUAD_W+IDX_W-1:QUAD_W];
        fidx   = quad[0] ? IDX_W'(SINE_ENTRIES) - idx : idx;
        mag    = TRIG_W'(SINE_TABLE[fidx]);
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // cosine is the sine one quarter turn ahead
    always_comb
    begin
        sine_next   = quarter_lookup(angle[ANGLE_BITS-1 -: 2], angle[QUAD_W-1:0]);
        cosine_next = quarter_lookup(angle[ANGLE_BITS-1 -: 2] + 2'd1, angle[QUAD_W-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sine_reg   <= sine_next;
            cosine_reg <= cosine_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pt3_mul.sv */
`default_nettype none

module pt3_mul import pt3_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire s1_t                    in_data,
    input  wire logic signed [TRIG_W-1:0] sine,
    input  wire logic signed [TRIG_W-1:0] cosine,
    output logic                        out_valid_reg,
    input  wire logic                   out_ready,
    output s2_t                         out_reg
);

    s2_t                            out_next;
    logic signed [DIFF_W-1:0]       du;
    logic signed [DIFF_W-1:0]       dv;
    logic signed [DIFF_W-1:0]       opa [4];
    logic signed [TRIG_W-1:0]       opb [4];
    logic signed [PASS_W-1:0]       addend [3];

    assign in_ready = !out_valid_reg || out_ready;

    // pick the rotation pair
    always_comb
    begin
        unique case (in_data.op)
            OP_ROT_X:
            begin
                du = $signed(in_data.d[1]);
                dv = $signed(in_data.d[2]);
            end
            OP_ROT_Y:
            begin
                du = $signed(in_data.d[2]);
                dv = $signed(in_data.d[0]);
            end
            default:
            begin
                du = $signed(in_data.d[0]);
                dv = $signed(in_data.d[1]);
            end
        endcase
    end

    // route operands to the four multipliers
    always_comb
    begin
        if (in_data.op == OP_SCALE)
        begin
            for (int i = 0; i < 3; i++)
            begin
                opa[i] = $signed(in_data.d[i]);
                opb[i] = TRIG_W'($signed(in_data.a[i]));
            end
            opa[3] = '0;
            opb[3] = '0;
        end
        else
        begin
            opa[0] = du;
            opb[0] = cosine;
            opa[1] = dv;
            opb[1] = sine;
            opa[2] = du;
            opb[2] = sine;
            opa[3] = dv;
            opb[3] = cosine;
        end
    end

    // form products and the pass-through lanes
    always_comb
    begin
        out_next.op = in_data.op;
        out_next.r  = in_data.r;
        for (int i = 0; i < 3; i++)
        begin
            addend[i] = (in_data.op == OP_TRANSLATE) ? PASS_W'($signed(in_data.a[i]))
                                                     : PASS_W'($signed(in_data.r[i]));
            out_next.t[i] = PASS_W'($signed(in_data.d[i])) + addend[i];
        end
        for (int k = 0; k < 4; k++)
        begin
            out_next.m[k] = PROD_W'(opa[k]) * PROD_W'(opb[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            out_reg <= out_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pt3_sat.sv */
`default_nettype none

module pt3_sat import pt3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire s3_t      in_data,
    pt3_stream_if.source  rsp
);

    localparam logic signed [COORD_BITS-1:0] MAX_C = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] MIN_C = {1'b1, {(COORD_BITS-1){1'b0}}};

    logic                          valid_reg;
    pt3_rsp_t                      data_reg;
    pt3_rsp_t                      data_next;
    logic signed [COORD_BITS-1:0]  lane [3];
    logic [2:0]                    clip;
    logic [SUM_W-1:0]              w;

    assign in_ready  = !valid_reg || rsp.ready;
    assign rsp.valid = valid_reg;
    assign rsp.data  = data_reg;

    // clamp each lane to the coordinate range
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            w       = in_data.w[i];
            clip[i] = !((&w[SUM_W-1:COORD_BITS-1]) || !(|w[SUM_W-1:COORD_BITS-1]));
            if (clip[i])
            begin
                lane[i] = w[SUM_W-1] ? MIN_C : MAX_C;
            end
            else
            begin
                lane[i] = $signed(w[COORD_BITS-1:0]);
            end
        end
        data_next.out_x    = FIELD_W'(lane[0]);
        data_next.out_y    = FIELD_W'(lane[1]);
        data_next.out_z    = FIELD_W'(lane[2]);
        data_next.overflow = |clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/point_transform_3d.sv */
// Each request is registered by s1_reg, u_mul, s3_reg and u_sat in that order.
// Throughput: one request per cycle unless the output stalls; the four multipliers
// are reused by rotate and scale, and each of the four stages holds one request.
// Reset: rst_n clears every valid bit asynchronously; data registers are not reset.
// The block keeps no state between requests.
`default_nettype none

module point_transform_3d import pt3_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    pt3_stream_if.sink   req,
    pt3_stream_if.source rsp
);

    logic                       s1_valid_reg;
    s1_t                        s1_reg;
    s1_t                        s1_next;
    logic                       s1_ready;
    logic signed [TRIG_W-1:0]   sine;
    logic signed [TRIG_W-1:0]   cosine;
    logic                       s2_in_ready;
    logic                       s2_valid;
    s2_t                        s2;
    logic                       s3_valid_reg;
    s3_t                        s3_reg;
    s3_t                        s3_next;
    logic                       s3_ready;
    logic                       sat_ready;
    logic                       relative;
    logic [COORD_BITS-1:0]      pin [3];
    logic [COORD_BITS-1:0]      rin [3];
    logic [COORD_BITS-1:0]      ain [3];
    logic signed [SUM_W-1:0]    rot_u;
    logic signed [SUM_W-1:0]    rot_v;
    logic signed [SUM_W-1:0]    r_u;
    logic signed [SUM_W-1:0]    r_v;
    logic signed [SUM_W-1:0]    pass [3];
    logic signed [SUM_W-1:0]    scl [3];

    assign s1_ready  = !s1_valid_reg || s2_in_ready;
    assign req.ready = s1_ready;

    // remove the reference point
    always_comb
    begin
        pin[0] = req.data.point_x[COORD_BITS-1:0];
        pin[1] = req.data.point_y[COORD_BITS-1:0];
        pin[2] = req.data.point_z[COORD_BITS-1:0];
        rin[0] = req.data.ref_x[COORD_BITS-1:0];
        rin[1] = req.data.ref_y[COORD_BITS-1:0];
        rin[2] = req.data.ref_z[COORD_BITS-1:0];
        ain[0] = req.data.arg_x[COORD_BITS-1:0];
        ain[1] = req.data.arg_y[COORD_BITS-1:0];
        ain[2] = req.data.arg_z[COORD_BITS-1:0];
        relative = req.data.about_ref &&
                   (req.data.operation == OP_ROT_X || req.data.operation == OP_ROT_Y ||
                    req.data.operation == OP_ROT_Z || req.data.operation == OP_SCALE);
        s1_next.op = req.data.operation;
        for (int i = 0; i < 3; i++)
        begin
            s1_next.r[i] = relative ? rin[i] : '0;
            s1_next.a[i] = ain[i];
            s1_next.d[i] = DIFF_W'($signed(pin[i])) - DIFF_W'($signed(s1_next.r[i]));
        end
    end

    pt3_sine_rom u_sine_rom (
        .clk        (clk),
        .en         (s1_ready && req.valid),
        .angle      (req.data.angle[ANGLE_BITS-1:0]),
        .sine_reg   (sine),
        .cosine_reg (cosine)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_reg <= s1_next;
        end
    end

    pt3_mul u_mul (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s1_valid_reg),
        .in_ready      (s2_in_ready),
        .in_data       (s1_reg),
        .sine          (sine),
        .cosine        (cosine),
        .out_valid_reg (s2_valid),
        .out_ready     (s3_ready),
        .out_reg       (s2)
    );

    // combine products, drop fraction bits, add the reference back
    always_comb
    begin
        unique case (s2.op)
            OP_ROT_X:
            begin
                r_u = SUM_W'($signed(s2.r[1]));
                r_v = SUM_W'($signed(s2.r[2]));
            end
            OP_ROT_Y:
            begin
                r_u = SUM_W'($signed(s2.r[2]));
                r_v = SUM_W'($signed(s2.r[0]));
            end
            default:
            begin
                r_u = SUM_W'($signed(s2.r[0]));
                r_v = SUM_W'($signed(s2.r[1]));
            end
        endcase
        rot_u = ((SUM_W'($signed(s2.m[0])) - SUM_W'($signed(s2.m[1]))) >>> TRIG_FRAC) + r_u;
        rot_v = ((SUM_W'($signed(s2.m[2])) + SUM_W'($signed(s2.m[3]))) >>> TRIG_FRAC) + r_v;
        for (int i = 0; i < 3; i++)
        begin
            pass[i] = SUM_W'($signed(s2.t[i]));
            scl[i]  = (SUM_W'($signed(s2.m[i])) >>> FRAC_BITS) + SUM_W'($signed(s2.r[i]));
        end
        unique case (s2.op)
            OP_ROT_X:
            begin
                s3_next.w[0] = pass[0];
                s3_next.w[1] = rot_u;
                s3_next.w[2] = rot_v;
            end
            OP_ROT_Y:
            begin
                s3_next.w[0] = rot_v;
                s3_next.w[1] = pass[1];
                s3_next.w[2] = rot_u;
            end
            OP_ROT_Z:
            begin
                s3_next.w[0] = rot_u;
                s3_next.w[1] = rot_v;
                s3_next.w[2] = pass[2];
            end
            OP_SCALE:
            begin
                s3_next.w[0] = scl[0];
                s3_next.w[1] = scl[1];
                s3_next.w[2] = scl[2];
            end
            default:
            begin
                s3_next.w[0] = pass[0];
                s3_next.w[1] = pass[1];
                s3_next.w[2] = pass[2];
            end
        endcase
    end

    assign s3_ready = !s3_valid_reg || sat_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid)
        begin
            s3_reg <= s3_next;
        end
    end

    pt3_sat u_sat (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid_reg),
        .in_ready (sat_ready),
        .in_data  (s3_reg),
        .rsp      (rsp)
    );

endmodule

`default_nettype wire

/* hw/rtl/pt3_checker.sv */
`default_nettype none

module pt3_checker import pt3_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     req_valid,
    input  wire logic     req_ready,
    input  wire logic     rsp_valid,
    input  wire logic     rsp_ready,
    input  wire pt3_rsp_t rsp_data
);

    localparam int DEPTH = 4;
    localparam logic signed [FIELD_W-1:0] MAX_C = {1'b0, {(FIELD_W-1){1'b1}}};
    localparam logic signed [FIELD_W-1:0] MIN_C = {1'b1, {(FIELD_W-1){1'b0}}};

    logic [2:0] pending_reg;
    logic [2:0] pending_next;

    // count requests in flight
    always_comb
    begin
        pending_next = pending_reg + 3'((req_valid && req_ready) ? 1 : 0)
                                   - 3'((rsp_valid && rsp_ready) ? 1 : 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result changed while stalled");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pending_reg != 3'd0)
        else $error("result without a request");

    a_depth: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg <= 3'(DEPTH))
        else $error("more requests in flight than stages");

    a_ovf_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.overflow |->
            rsp_data.out_x == MAX_C || rsp_data.out_x == MIN_C ||
            rsp_data.out_y == MAX_C || rsp_data.out_y == MIN_C ||
            rsp_data.out_z == MAX_C || rsp_data.out_z == MIN_C)
        else $error("overflow without a clamped coordinate");

endmodule

bind point_transform_3d pt3_checker u_pt3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire
